// ===== hdl/brge_pkg.sv =====
`timescale 1ns / 1ps

package brge_pkg;

    // Widths sized for the largest supported block of sixteen words.
    localparam int NW_W   = 5;    // word count in a block, 0..16
    localparam int NB_W   = 11;   // bit count in a block, 0..1024
    localparam int GS_W   = 12;   // summed gamma length of one block
    localparam int ADDR_W = 4;    // word address inside one bank

    localparam logic [2:0] STYLE_GAMMA0 = 3'd0;
    localparam logic [2:0] STYLE_GAMMA1 = 3'd1;
    localparam logic [2:0] STYLE_PLAIN  = 3'd2;
    localparam logic [2:0] STYLE_ALL0   = 3'd3;
    localparam logic [2:0] STYLE_ALL1   = 3'd4;

    localparam logic [7:0] CFG_BLOCK_WORDS  = 8'd0;
    localparam logic [7:0] CFG_PLAIN_MARGIN = 8'd1;

    // Description of one closed block, passed from the front to the back.
    typedef struct packed {
        logic [NW_W-1:0] nwords;
        logic [NB_W-1:0] nbits;
        logic [6:0]      take;
        logic            fin;
    } desc_t;

    // Write into the block buffer.
    typedef struct packed {
        logic              en;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [63:0]       data;
    } memwr_t;

    // One result item.
    typedef struct packed {
        logic        style_valid;
        logic [2:0]  style_code;
        logic        word_valid;
        logic [63:0] packed_word;
        logic        stream_end;
    } result_t;

endpackage

// ===== hdl/brge_front.sv =====
`timescale 1ns / 1ps

module brge_front #(
    parameter int MAX_BLOCK_WORDS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [63:0]           in_word,
    input  logic [6:0]            in_vbits,
    input  logic                  in_fin,
    input  logic [4:0]            block_words,
    input  logic                  bank_free,
    output brge_pkg::memwr_t      mem_wr,
    output logic                  q_push,
    output brge_pkg::desc_t       q_desc
);

    localparam logic [brge_pkg::NW_W-1:0] MAXW = brge_pkg::NW_W'(MAX_BLOCK_WORDS);

    logic [brge_pkg::NW_W-1:0] words_reg, words_next;
    logic [brge_pkg::NB_W-1:0] bits_reg, bits_next;
    logic                      bank_reg, bank_next;

    logic [brge_pkg::NW_W-1:0] eff;
    logic [6:0]                take;
    logic [brge_pkg::NW_W-1:0] wcount;
    logic [brge_pkg::NB_W-1:0] bcount;
    logic                      accept, close;

    assign in_ready = bank_free;
    assign accept   = in_valid && in_ready;

    always_comb begin
        if (block_words == '0) begin
            eff = brge_pkg::NW_W'(1);
        end else if (block_words > MAXW) begin
            eff = MAXW;
        end else begin
            eff = block_words;
        end
        take = (in_fin && in_vbits >= 7'd1 && in_vbits < 7'd64) ? in_vbits : 7'd64;
        wcount = words_reg + brge_pkg::NW_W'(1);
        bcount = bits_reg + brge_pkg::NB_W'(take);
        close  = in_fin || (wcount >= eff);

        mem_wr.en   = accept;
        mem_wr.bank = bank_reg;
        mem_wr.addr = words_reg[brge_pkg::ADDR_W-1:0];
        // Keep only the leading take bits; the rest never reach the stream.
        mem_wr.data = in_word & ~({64{1'b1}} >> take);

        q_push        = accept && close;
        q_desc.nwords = wcount;
        q_desc.nbits  = bcount;
        q_desc.take   = take;
        q_desc.fin    = in_fin;

        words_next = words_reg;
        bits_next  = bits_reg;
        bank_next  = bank_reg;
        if (accept) begin
            if (close) begin
                words_next = '0;
                bits_next  = '0;
                bank_next  = !bank_reg;
            end else begin
                words_next = wcount;
                bits_next  = bcount;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg <= '0;
            bits_reg  <= '0;
            bank_reg  <= 1'b0;
        end else begin
            words_reg <= words_next;
            bits_reg  <= bits_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

// ===== hdl/brge_queue.sv =====
`timescale 1ns / 1ps

module brge_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  brge_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            head_valid,
    output brge_pkg::desc_t head_desc
);

    brge_pkg::desc_t slot_reg [2];
    logic            wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]      cnt_reg, cnt_next;

    always_comb begin
        head_valid = (cnt_reg != 2'd0);
        head_desc  = slot_reg[rp_reg];
        wp_next    = push ? !wp_reg : wp_reg;
        rp_next    = pop ? !rp_reg : rp_reg;
        cnt_next   = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/brge_back.sv =====
`timescale 1ns / 1ps

module brge_back #(
    parameter int MAX_BLOCK_WORDS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  brge_pkg::memwr_t  mem_wr,
    input  logic              q_valid,
    input  brge_pkg::desc_t   q_desc,
    output logic              q_pop,
    output logic              blk_done,
    input  logic [7:0]        plain_margin,
    output logic              out_valid,
    input  logic              out_ready,
    output brge_pkg::result_t out_res
);

    localparam int AW    = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
    localparam int DEPTH = 2 ** (AW + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_SCAN = 6'b000100,
        S_STY  = 6'b001000,
        S_PLN  = 6'b010000,
        S_END  = 6'b100000
    } state_t;

    typedef struct packed {
        logic        emit;
        logic [63:0] word;
        logic [63:0] preg;
        logic [6:0]  fill;
    } pack_t;

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    state_t                        state_reg, state_next;
    brge_pkg::desc_t               d_reg, d_next;
    logic                          bank_reg, bank_next;
    logic                          emit_reg, emit_next;
    logic                          plain_reg, plain_next;
    logic [brge_pkg::NW_W-1:0]     widx_reg, widx_next;
    logic [6:0]                    pos_reg, pos_next;
    logic [brge_pkg::NB_W-1:0]     left_reg, left_next;
    logic [brge_pkg::NB_W-1:0]     run_reg, run_next;
    logic                          runb_reg, runb_next;
    logic                          first_reg, first_next;
    logic                          have_reg, have_next;
    logic                          many_reg, many_next;
    logic [brge_pkg::GS_W-1:0]     gsum_reg, gsum_next;
    logic [63:0]                   pack_reg, pack_next;
    logic [6:0]                    fill_reg, fill_next;
    logic                          hold_v_reg, hold_v_next;
    brge_pkg::result_t             hold_reg, hold_next;
    logic                          outv_reg, outv_next;
    brge_pkg::result_t             outr_reg, outr_next;

    logic              can_push, push_en;
    brge_pkg::result_t res_new;
    logic [63:0]       x;
    logic [6:0]        lz, room, avail, cnt;
    logic              brk, fin_blk, close, go;
    logic [brge_pkg::NB_W-1:0] r_close;
    logic [3:0]        blen;
    logic [63:0]       pk_val;
    logic [6:0]        pk_len;
    pack_t             pk;
    logic [6:0]        plen;
    logic              last_word;
    logic [2:0]        style;
    logic [12:0]       thr_lhs;
    logic [12:0]       thr_rhs;

    // Length of the run of equal bits that opens a word.
    function automatic logic [6:0] lead_len(input logic [63:0] v);
        logic [63:0] d;
        logic [6:0]  n;
        logic        stop;
        d    = v ^ {64{v[63]}};
        n    = 7'd0;
        stop = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!stop && !d[i]) begin
                n = n + 7'd1;
            end else begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [3:0] bit_len(input logic [brge_pkg::NB_W-1:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < brge_pkg::NB_W; i++) begin
            if (v[i]) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

    function automatic pack_t pack_bits(input logic [63:0] preg, input logic [6:0] fill,
                                        input logic [63:0] val, input logic [6:0] len);
        pack_t       p;
        logic [63:0] v;
        logic [6:0]  freeb, over, nfill;
        v     = val & ~({64{1'b1}} << len);
        if (len == 7'd64) begin
            v = val;
        end
        freeb = 7'd64 - fill;
        p.emit = 1'b0;
        p.word = '0;
        if (len <= freeb) begin
            p.preg = preg | (v << (freeb - len));
            nfill  = fill + len;
            p.fill = nfill;
            if (nfill == 7'd64) begin
                p.emit = 1'b1;
                p.word = p.preg;
                p.preg = '0;
                p.fill = 7'd0;
            end
        end else begin
            over   = len - freeb;
            p.emit = 1'b1;
            p.word = preg | (v >> over);
            p.preg = v << (7'd64 - over);
            p.fill = over;
        end
        return p;
    endfunction

    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            mem[{mem_wr.bank, mem_wr.addr[AW-1:0]}] <= mem_wr.data;
        end
        rdata_reg <= mem[{bank_reg, widx_reg[AW-1:0]}];
    end

    assign can_push  = !hold_v_reg || !outv_reg || out_ready;
    assign out_valid = outv_reg;
    assign out_res   = outr_reg;

    always_comb begin
        // Run scan over the current word.
        x       = rdata_reg << pos_reg[5:0];
        lz      = lead_len(x);
        room    = 7'd64 - pos_reg;
        avail   = (left_reg < brge_pkg::NB_W'(room)) ? left_reg[6:0] : room;
        cnt     = (lz < avail) ? lz : avail;
        brk     = (run_reg != '0) && (x[63] != runb_reg);
        r_close = brk ? run_reg : run_reg + brge_pkg::NB_W'(cnt);
        fin_blk = !brk && (left_reg == brge_pkg::NB_W'(cnt));
        close   = brk || fin_blk;
        blen    = bit_len(r_close);

        last_word = (widx_reg + brge_pkg::NW_W'(1) == d_reg.nwords);
        plen      = (d_reg.fin && last_word) ? d_reg.take : 7'd64;

        if (state_reg == S_PLN) begin
            pk_val = rdata_reg >> (7'd64 - plen);
            pk_len = plen;
        end else begin
            // Gamma code: zeros then the run length, one field of 2L-1 bits.
            pk_val = 64'(r_close);
            pk_len = 7'({blen, 1'b0}) - 7'd1;
        end
        pk = pack_bits(pack_reg, fill_reg, pk_val, pk_len);

        thr_lhs = 13'(gsum_reg) + 13'(plain_margin);
        thr_rhs = 13'({d_reg.nwords, 6'b0});
        if (!many_reg) begin
            style = first_reg ? brge_pkg::STYLE_ALL1 : brge_pkg::STYLE_ALL0;
        end else if (d_reg.fin || thr_lhs >= thr_rhs) begin
            style = brge_pkg::STYLE_PLAIN;
        end else begin
            style = first_reg ? brge_pkg::STYLE_GAMMA1 : brge_pkg::STYLE_GAMMA0;
        end

        state_next = state_reg;
        d_next     = d_reg;
        bank_next  = bank_reg;
        emit_next  = emit_reg;
        plain_next = plain_reg;
        widx_next  = widx_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        run_next   = run_reg;
        runb_next  = runb_reg;
        first_next = first_reg;
        have_next  = have_reg;
        many_next  = many_reg;
        gsum_next  = gsum_reg;
        pack_next  = pack_reg;
        fill_next  = fill_reg;
        q_pop      = 1'b0;
        blk_done   = 1'b0;
        push_en    = 1'b0;
        res_new    = '0;
        go         = 1'b0;
        hold_next  = hold_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    d_next     = q_desc;
                    emit_next  = 1'b0;
                    plain_next = 1'b0;
                    widx_next  = '0;
                    pos_next   = 7'd0;
                    left_next  = q_desc.nbits;
                    run_next   = '0;
                    have_next  = 1'b0;
                    many_next  = 1'b0;
                    gsum_next  = '0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = plain_reg ? S_PLN : S_SCAN;
            end
            S_SCAN: begin
                go = !(emit_reg && close) || can_push;
                if (go) begin
                    if (brk) begin
                        run_next = '0;
                    end else begin
                        if (!emit_reg && !have_reg && run_reg == '0) begin
                            first_next = x[63];
                        end
                        run_next  = fin_blk ? '0 : run_reg + brge_pkg::NB_W'(cnt);
                        runb_next = x[63];
                        pos_next  = pos_reg + cnt;
                        left_next = left_reg - brge_pkg::NB_W'(cnt);
                        if (!fin_blk && pos_reg + cnt == 7'd64) begin
                            widx_next  = widx_reg + brge_pkg::NW_W'(1);
                            pos_next   = 7'd0;
                            state_next = S_RD;
                        end
                    end
                    if (close) begin
                        if (emit_reg) begin
                            pack_next = pk.preg;
                            fill_next = pk.fill;
                            if (pk.emit) begin
                                push_en             = 1'b1;
                                res_new.word_valid  = 1'b1;
                                res_new.packed_word = pk.word;
                            end
                        end else begin
                            gsum_next = gsum_reg + brge_pkg::GS_W'(pk_len);
                            have_next = 1'b1;
                            many_next = have_reg;
                        end
                    end
                    if (fin_blk) begin
                        state_next = emit_reg ? S_END : S_STY;
                    end
                end
            end
            S_STY: begin
                if (can_push) begin
                    push_en             = 1'b1;
                    res_new.style_valid = 1'b1;
                    res_new.style_code  = style;
                    widx_next           = '0;
                    pos_next            = 7'd0;
                    left_next           = d_reg.nbits;
                    run_next            = '0;
                    if (style == brge_pkg::STYLE_PLAIN) begin
                        plain_next = 1'b1;
                        state_next = S_RD;
                    end else if (style == brge_pkg::STYLE_GAMMA0 ||
                                 style == brge_pkg::STYLE_GAMMA1) begin
                        emit_next  = 1'b1;
                        state_next = S_RD;
                    end else begin
                        state_next = S_END;
                    end
                end
            end
            S_PLN: begin
                if (can_push) begin
                    pack_next = pk.preg;
                    fill_next = pk.fill;
                    if (pk.emit) begin
                        push_en             = 1'b1;
                        res_new.word_valid  = 1'b1;
                        res_new.packed_word = pk.word;
                    end
                    if (last_word) begin
                        state_next = S_END;
                    end else begin
                        widx_next  = widx_reg + brge_pkg::NW_W'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_END: begin
                if (!d_reg.fin) begin
                    blk_done   = 1'b1;
                    bank_next  = !bank_reg;
                    state_next = S_IDLE;
                end else if (fill_reg == 7'd0) begin
                    // The pending result is the last of the bitmap.
                    hold_next.stream_end = 1'b1;
                    pack_next  = '0;
                    blk_done   = 1'b1;
                    bank_next  = !bank_reg;
                    state_next = S_IDLE;
                end else if (can_push) begin
                    push_en             = 1'b1;
                    res_new.word_valid  = 1'b1;
                    res_new.packed_word = pack_reg;
                    res_new.stream_end  = 1'b1;
                    pack_next  = '0;
                    fill_next  = 7'd0;
                    blk_done   = 1'b1;
                    bank_next  = !bank_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Results wait one place in the hold stage so that the end mark can
        // still be set on the last one.
        outv_next   = outv_reg && !out_ready;
        outr_next   = outr_reg;
        hold_v_next = hold_v_reg;
        if (push_en) begin
            if (hold_v_reg) begin
                outv_next = 1'b1;
                outr_next = hold_reg;
            end
            hold_next   = res_new;
            hold_v_next = 1'b1;
        end else if (state_reg == S_IDLE && hold_v_reg && (!outv_reg || out_ready)) begin
            outv_next   = 1'b1;
            outr_next   = hold_reg;
            hold_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        d_reg     <= d_next;
        widx_reg  <= widx_next;
        pos_reg   <= pos_next;
        left_reg  <= left_next;
        run_reg   <= run_next;
        runb_reg  <= runb_next;
        first_reg <= first_next;
        gsum_reg  <= gsum_next;
        hold_reg  <= hold_next;
        outr_reg  <= outr_next;
        emit_reg  <= emit_next;
        plain_reg <= plain_next;
        have_reg  <= have_next;
        many_reg  <= many_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            bank_reg   <= 1'b0;
            pack_reg   <= '0;
            fill_reg   <= 7'd0;
            hold_v_reg <= 1'b0;
            outv_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            bank_reg   <= bank_next;
            pack_reg   <= pack_next;
            fill_reg   <= fill_next;
            hold_v_reg <= hold_v_next;
            outv_reg   <= outv_next;
        end
    end

endmodule

// ===== hdl/block_rl_gamma_bitmap_encoder.sv =====
`timescale 1ns / 1ps

// Block run-length / Elias-gamma bitmap encoder. Bitmap words enter MSB first and are
// gathered into blocks of block_words words; each closed block yields one style item
// (all zeros, all ones, plain, or gamma coded with first bit 0 or 1) followed by the
// packed 64-bit stream words it completes, and the final block also flushes the partial
// word, with m_tlast on the very last item. The front takes one word per cycle into one
// of two block banks, so a whole block is accepted back to back while the previous
// block is still being coded. The back first walks each block with a leading-run
// detector to choose the style, fetching each word from the bank memory, scanning
// it run segment by run segment and closing a run that ends before the block does.
// A gamma block is then walked again the same way to emit its codes and a plain block
// is read again word by word; all-zero and all-one blocks need no second walk. So
// throughput depends on the run count, and input stalls only when both banks hold
// blocks still waiting for the back.
// Configuration writes are always ready and must only be made while the block is idle.

module block_rl_gamma_bitmap_encoder #(
    parameter int MAX_BLOCK_WORDS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] bitmap_word, [70:64] valid_bits, [71] zero
    input  logic        s_tlast,   // final_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [2:0] style_code, [66:3] packed_word, [71:67] zero
    output logic [1:0]  m_tuser,   // [0] style_valid, [1] word_valid
    output logic        m_tlast,   // stream_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [4:0]        block_words_reg;
    logic [7:0]        plain_margin_reg;
    logic [1:0]        blocks_reg, blocks_next;

    brge_pkg::memwr_t  mem_wr;
    logic              q_push, q_pop, q_valid, blk_done;
    brge_pkg::desc_t   push_desc, head_desc;
    brge_pkg::result_t res;

    // Registers are always writable; a write to an unknown index is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_words_reg  <= 5'd4;
            plain_margin_reg <= 8'd20;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == brge_pkg::CFG_BLOCK_WORDS) begin
                block_words_reg <= cfg_data[4:0];
            end else if (cfg_index == brge_pkg::CFG_PLAIN_MARGIN) begin
                plain_margin_reg <= cfg_data;
            end
        end
    end

    // Count of closed blocks whose bank the back still owns.
    always_comb begin
        blocks_next = blocks_reg + 2'(q_push) - 2'(blk_done);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_reg <= 2'd0;
        end else begin
            blocks_reg <= blocks_next;
        end
    end

    brge_front #(
        .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_word     (s_tdata[63:0]),
        .in_vbits    (s_tdata[70:64]),
        .in_fin      (s_tlast),
        .block_words (block_words_reg),
        .bank_free   (blocks_reg < 2'd2),
        .mem_wr      (mem_wr),
        .q_push      (q_push),
        .q_desc      (push_desc)
    );

    brge_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (push_desc),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_desc  (head_desc)
    );

    brge_back #(
        .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mem_wr       (mem_wr),
        .q_valid      (q_valid),
        .q_desc       (head_desc),
        .q_pop        (q_pop),
        .blk_done     (blk_done),
        .plain_margin (plain_margin_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_res      (res)
    );

    assign m_tdata = {5'd0, res.packed_word, res.style_code};
    assign m_tuser = {res.word_valid, res.style_valid};
    assign m_tlast = res.stream_end;

endmodule

// ===== hdl/brge_checker.sv =====
`timescale 1ns / 1ps

module brge_out_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled item holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Every item carries exactly one of a style code or a packed word.
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tuser))
        else $error("output item carries neither or both kinds");

    // A style code lies in range, and fields not carried read as zero.
    a_style: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[2:0] <= 3'd4 && m_tdata[66:3] == 64'd0)
        else $error("bad style item");

    a_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[2:0] == 3'd0)
        else $error("word item has a style code");

endmodule

bind block_rl_gamma_bitmap_encoder brge_out_checker u_brge_out_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== test/brge_checker.sv =====
`timescale 1ns / 1ps

// Watches the input, configuration and result channels of the encoder.
// It keeps its own copy of the block state, predicts the result items of
// every accepted input item and compares them in order.
module brge_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          outstanding
);

    logic [63:0]       blk_words[16];
    int unsigned       words_held;
    int unsigned       bits_held;
    logic [63:0]       pack_acc;
    int unsigned       pack_fill;
    logic [4:0]        block_len_reg;
    logic [7:0]        margin_reg;
    brge_pkg::result_t expected_q[$];

    function automatic bit bitmap_bit(int unsigned i);
        return blk_words[(i >> 6) % 16][63 - (i & 63)];
    endfunction

    task automatic push_result(bit sv, logic [2:0] sc, bit wv, logic [63:0] w);
        brge_pkg::result_t r;
        r.style_valid = sv;
        r.style_code  = sc;
        r.word_valid  = wv;
        r.packed_word = w;
        r.stream_end  = 1'b0;
        expected_q.push_back(r);
    endtask

    task automatic append_bits(logic [63:0] v, int unsigned len);
        int unsigned room;
        int unsigned over;
        if (len == 0 || len > 64) return;
        if (len < 64) v &= (64'd1 << len) - 64'd1;
        room = 64 - pack_fill;
        if (len <= room) begin
            pack_acc |= v << (room - len);
            pack_fill += len;
            if (pack_fill == 64) begin
                push_result(1'b0, 3'd0, 1'b1, pack_acc);
                pack_acc = '0;
                pack_fill = 0;
            end
        end else begin
            over = len - room;
            pack_acc |= v >> over;
            push_result(1'b0, 3'd0, 1'b1, pack_acc);
            pack_acc = v << (64 - over);
            pack_fill = over;
        end
    endtask

    // Splits the block into runs; sums the gamma code lengths and, when asked,
    // appends the gamma codes to the stream.
    task automatic scan_runs(int unsigned n, bit emit, output int unsigned gsum,
                             output int unsigned nruns);
        int unsigned i;
        int unsigned r;
        int unsigned len;
        bit b;
        i = 0;
        gsum = 0;
        nruns = 0;
        while (i < n) begin
            b = bitmap_bit(i);
            r = 0;
            while (i < n && bitmap_bit(i) == b) begin
                i++;
                r++;
            end
            len = $clog2(r + 1);
            gsum += 2 * len - 1;
            nruns++;
            if (emit) begin
                append_bits(64'd0, len - 1);
                append_bits(64'(r), len);
            end
        end
    endtask

    task automatic predict_item(logic [63:0] w, logic [6:0] vb, bit fin);
        int unsigned eff;
        int unsigned take;
        int unsigned gsum;
        int unsigned nruns;
        int unsigned len;
        int          limit;
        logic [2:0]  style;
        eff = block_len_reg;
        if (eff == 0) eff = 1;
        if (eff > 16) eff = 16;
        take = (fin && vb >= 1 && vb < 64) ? vb : 64;
        if (take < 64) w &= ~((64'd1 << (64 - take)) - 64'd1);
        if (words_held >= 16) words_held = 15;
        blk_words[words_held] = w;
        words_held++;
        bits_held += take;
        if (!fin && words_held < eff) return;

        scan_runs(bits_held, 1'b0, gsum, nruns);
        limit = int'(words_held * 64) - int'(margin_reg);
        if (nruns == 1)
            style = bitmap_bit(0) ? brge_pkg::STYLE_ALL1 : brge_pkg::STYLE_ALL0;
        else if (fin || int'(gsum) >= limit)
            style = brge_pkg::STYLE_PLAIN;
        else
            style = bitmap_bit(0) ? brge_pkg::STYLE_GAMMA1 : brge_pkg::STYLE_GAMMA0;
        push_result(1'b1, style, 1'b0, 64'd0);

        if (style == brge_pkg::STYLE_PLAIN) begin
            for (int unsigned i = 0; i < words_held; i++) begin
                len = (fin && i + 1 == words_held) ? take : 64;
                append_bits(blk_words[i] >> (64 - len), len);
            end
        end else if (style == brge_pkg::STYLE_GAMMA0 || style == brge_pkg::STYLE_GAMMA1) begin
            scan_runs(bits_held, 1'b1, gsum, nruns);
        end

        if (fin) begin
            if (pack_fill > 0) push_result(1'b0, 3'd0, 1'b1, pack_acc);
            expected_q[$].stream_end = 1'b1;
            pack_acc = '0;
            pack_fill = 0;
        end
        words_held = 0;
        bits_held = 0;
    endtask

    always @(posedge aclk) begin
        brge_pkg::result_t got;
        brge_pkg::result_t want;
        if (!aresetn) begin
            words_held = 0;
            bits_held = 0;
            pack_acc = '0;
            pack_fill = 0;
            block_len_reg = 5'd4;
            margin_reg = 8'd20;
            expected_q.delete();
            fail_count = 0;
        end else begin
            // Results are checked before the new input is predicted, so an item
            // arriving in the same cycle can never be matched against itself.
            if (m_tvalid && m_tready) begin
                got.style_valid = m_tuser[0];
                got.style_code  = m_tdata[2:0];
                got.word_valid  = m_tuser[1];
                got.packed_word = m_tdata[66:3];
                got.stream_end  = m_tlast;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result item %p", $realtime, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.style_valid !== want.style_valid
                        || got.style_code !== want.style_code
                        || got.word_valid !== want.word_valid
                        || got.packed_word !== want.packed_word
                        || got.stream_end !== want.stream_end) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: result mismatch, expected %p, got %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == brge_pkg::CFG_BLOCK_WORDS)
                    block_len_reg = cfg_data[4:0];
                else if (cfg_index == brge_pkg::CFG_PLAIN_MARGIN)
                    margin_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_item(s_tdata[63:0], s_tdata[70:64], s_tlast);
        end
        outstanding = expected_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Top of the encoder testbench. It produces bitmaps and configuration
// writes, applies random back-pressure on the result side and gives the
// verdict; all prediction and comparison lives in the checker.
module tb_top;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [7:0]  cfg_data;
    int          fail_count;
    int          outstanding;

    // While set, neither side inserts idle cycles.
    bit          steady;

    block_rl_gamma_bitmap_encoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    brge_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // The receiver stalls in roughly one cycle out of ten, except in the
    // steady stretch.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 10);
    end

    // Offers one bitmap word and returns at the edge where it is taken.
    // The valid line is only lowered for a random gap, never in the step
    // where it is raised again.
    task automatic send_word(logic [63:0] w, logic [6:0] vb, bit fin);
        if (!steady && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, vb, w};
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Waits until every expected result has arrived, then lets the back end
    // finish any block it may still be walking before registers change.
    task automatic drain_to_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (2500) @(posedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly words with only a few runs, so that gamma coding wins often;
    // the rest are uniform or fully random words.
    function automatic logic [63:0] make_word();
        logic [63:0] w;
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick <= 5) begin
            w = $urandom_range(1) ? '1 : '0;
            repeat ($urandom_range(3)) w ^= ~64'd0 >> $urandom_range(63);
        end else if (pick == 6) begin
            w = '0;
        end else if (pick == 7) begin
            w = '1;
        end else begin
            w = {$urandom, $urandom};
        end
        return w;
    endfunction

    // One bitmap of random length; the valid bit count covers the whole
    // field, including zero and values above 64 on the final word.
    task automatic send_bitmap(int unsigned nwords, inout int unsigned sent);
        for (int unsigned i = 0; i < nwords; i++) begin
            send_word(make_word(), 7'($urandom_range(127)), i + 1 == nwords);
            sent++;
        end
    endtask

    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int unsigned sent;
        int unsigned phase;
        logic [7:0] bw_set[6];
        logic [7:0] mg_set[6];
        bw_set = '{8'd1, 8'd16, 8'd2, 8'd0, 8'd31, 8'd8};
        mg_set = '{8'd0, 8'd255, 8'd20, 8'd40, 8'd0, 8'd255};

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        steady    = 1'b0;
        sent      = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset settings: single-word bitmaps, uniform and
        // mixed, with one bit, zero and out-of-range valid counts on the final word.
        send_word('0, 7'd64, 1'b1);
        send_word('1, 7'd1, 1'b1);
        send_word(64'h8000_0000_0000_0000, 7'd0, 1'b1);
        send_word(64'hFFFF_0000_FFFF_FFFF, 7'd127, 1'b1);
        send_word(64'h0000_0000_0000_00FF, 7'd8, 1'b1);
        // A block with few runs, so gamma coded starting with one, and then
        // one starting with zero; valid counts on words that are not final are ignored.
        send_word(64'hFFFF_FFFF_0000_0000, 7'd5, 1'b0);
        send_word('0, 7'd0, 1'b0);
        send_word('1, 7'd64, 1'b0);
        send_word(64'hFFF0_0000_0000_0000, 7'd64, 1'b0);
        send_word(64'h0000_0000_0FFF_FFFF, 7'd64, 1'b0);
        send_word('0, 7'd64, 1'b0);
        send_word('0, 7'd64, 1'b0);
        send_word('1, 7'd64, 1'b0);
        // A noisy block that must fall back to plain coding.
        send_word(64'h5555_AAAA_1234_5678, 7'd64, 1'b0);
        send_word(64'hDEAD_BEEF_CAFE_F00D, 7'd64, 1'b0);
        send_word(64'h0F0F_0F0F_F0F0_F0F0, 7'd64, 1'b0);
        send_word(64'h3C3C_A5A5_6996_1EE1, 7'd64, 1'b0);
        // Block length lowered part-way through a block: the next word
        // closes the block at the size gathered so far.
        send_word(64'h0000_FFFF_FFFF_FFFF, 7'd64, 1'b0);
        send_word('1, 7'd64, 1'b0);
        drain_to_idle();
        write_reg(brge_pkg::CFG_BLOCK_WORDS, 8'd1);
        send_word(64'hFFFF_FF00_0000_0000, 7'd64, 1'b0);
        send_word(64'hF000_0000_0000_0001, 7'd33, 1'b1);
        drain_to_idle();

        // Random part in phases with different settings; the fourth phase
        // runs without any idling on either side.
        for (phase = 0; phase < 6; phase++) begin
            write_reg(brge_pkg::CFG_BLOCK_WORDS, bw_set[phase] | 8'($urandom_range(7) << 5));
            write_reg(brge_pkg::CFG_PLAIN_MARGIN, mg_set[phase]);
            steady = (phase == 3);
            while (sent < (phase + 1) * 25) begin
                if ($urandom_range(9) < 7)
                    send_bitmap($urandom_range(1, 3 * (bw_set[phase] & 8'h0f) + 2), sent);
                else
                    send_bitmap($urandom_range(1, 4), sent);
            end
            drain_to_idle();
        end
        steady = 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
